### rtl/semq_pkg.sv
// Shared types, constants and helper functions of the semaphore table.
`timescale 1ns / 1ps

package semq_pkg;

  // Table and queue sizes.
  localparam int NumSem     = 16;
  localparam int QueueDepth = 8;
  localparam int TaskBits   = 8;

  // Derived widths.
  localparam int SlotW  = (NumSem > 1) ? $clog2(NumSem) : 1;
  localparam int QPosW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QLenW  = $clog2(QueueDepth + 1);
  localparam int WAddrW = (NumSem * QueueDepth > 1) ? $clog2(NumSem * QueueDepth) : 1;

  // Fixed field widths.
  localparam int IdW     = 16;
  localparam int InitW   = 17;
  localparam int CallerW = 8;
  localparam int NextIdW = 17;
  localparam int CountW  = 18;

  localparam logic signed [CountW-1:0] CountMax = 18'sd65535;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_DOWN   = 2'd1,
    ACT_UP     = 2'd2,
    ACT_CLOSE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_MODIFY,
    S_WAKE,
    S_FINISH
  } state_e;

  // Per-slot record kept in the record memory.
  typedef struct packed {
    logic signed [CountW-1:0] count;
    logic [QPosW-1:0]         head;
    logic [QLenW-1:0]         len;
  } rec_t;

  // Updates to the id directory.
  typedef struct packed {
    logic             alloc;
    logic [SlotW-1:0] alloc_slot;
    logic [IdW-1:0]   alloc_ident;
    logic             free_en;
    logic [SlotW-1:0] free_slot;
  } dir_wr_t;

  // Lookup answer of the id directory.
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] hit_slot;
    logic             has_free;
    logic [SlotW-1:0] free_slot;
  } dir_rsp_t;

  // One result item.
  typedef struct packed {
    status_e              status;
    logic [IdW-1:0]       created_id;
    logic                 sleeps;
    logic                 wake_valid;
    logic [CallerW-1:0]   wake_task;
  } res_t;

  // Queue position that lies off entries after head, wrapped in the window.
  function automatic logic [QPosW-1:0] qpos(logic [QPosW-1:0] head, logic [QLenW-1:0] off);
    logic [QLenW+QPosW-1:0] sum;
    sum = (QLenW + QPosW)'(head) + (QLenW + QPosW)'(off);
    if (sum >= (QLenW + QPosW)'(QueueDepth)) begin
      sum = sum - (QLenW + QPosW)'(QueueDepth);
    end
    return QPosW'(sum);
  endfunction

  // Waiter memory address of a queue position within a slot's window.
  function automatic logic [WAddrW-1:0] waddr(logic [SlotW-1:0] slot, logic [QPosW-1:0] pos);
    return WAddrW'(slot) * WAddrW'(QueueDepth) + WAddrW'(pos);
  endfunction

endpackage

### rtl/semq_req_if.sv
// Request channel: one action item toward the semaphore table.
`timescale 1ns / 1ps

interface semq_req_if;
  import semq_pkg::*;

  logic                     valid;
  logic                     ready;
  action_e                  action;
  logic [IdW-1:0]           target_id;
  logic signed [InitW-1:0]  initial_count;
  logic [CallerW-1:0]       caller_task;

  modport source (output valid, action, target_id, initial_count, caller_task, input ready);
  modport sink (input valid, action, target_id, initial_count, caller_task, output ready);
endinterface

### rtl/semq_rsp_if.sv
// Response channel: one result item from the semaphore table.
`timescale 1ns / 1ps

interface semq_rsp_if;
  import semq_pkg::*;

  logic               valid;
  logic               ready;
  status_e            status;
  logic [IdW-1:0]     created_id;
  logic               caller_sleeps;
  logic               wake_valid;
  logic [CallerW-1:0] wake_task;

  modport source (output valid, status, created_id, caller_sleeps, wake_valid, wake_task,
                  input ready);
  modport sink (input valid, status, created_id, caller_sleeps, wake_valid, wake_task,
                output ready);
endinterface

### rtl/semq_dir.sv
// Id directory: in-use flags and ids of all slots, with parallel id match.
`timescale 1ns / 1ps

module semq_dir (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [semq_pkg::IdW-1:0]  lookup_id_i,
  input  semq_pkg::dir_wr_t         wr_i,
  output semq_pkg::dir_rsp_t        rsp_o
);
  import semq_pkg::*;

  logic [NumSem-1:0] in_use_q, in_use_d;
  logic [IdW-1:0]    ident_q [NumSem];

  // Allocation sets a flag, closing clears it.
  always_comb begin
    in_use_d = in_use_q;
    if (wr_i.alloc) begin
      in_use_d[wr_i.alloc_slot] = 1'b1;
    end
    if (wr_i.free_en) begin
      in_use_d[wr_i.free_slot] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
    end else begin
      in_use_q <= in_use_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.alloc) begin
      ident_q[wr_i.alloc_slot] <= wr_i.alloc_ident;
    end
  end

  // Ids in use are unique, so at most one slot matches and the OR encodes it.
  // The free search keeps the lowest free slot.
  always_comb begin
    rsp_o = '0;
    for (int i = 0; i < NumSem; i++) begin
      if (in_use_q[i] && ident_q[i] == lookup_id_i) begin
        rsp_o.hit      = 1'b1;
        rsp_o.hit_slot = rsp_o.hit_slot | SlotW'(i);
      end
    end
    for (int j = NumSem - 1; j >= 0; j--) begin
      if (!in_use_q[j]) begin
        rsp_o.has_free  = 1'b1;
        rsp_o.free_slot = SlotW'(j);
      end
    end
  end

endmodule

### rtl/semaphore_table_with_wait_queues.sv
// Top level of the counting semaphore table with FIFO wait queues.
`timescale 1ns / 1ps

// The block serves one request item at a time and answers each with exactly
// one result item. A create or a request with an unknown id passes the lookup
// and finish states; down, close and an up without a waiter pass lookup,
// modify and finish, and an up that wakes a waiter also passes the wake state.
// Modify waits on the record memory read, and wake on the waiter memory read
// that depends on it. A finished result sits in an output register, so a
// stalled response side holds the block only when a second result is done
// before the first has been taken. Ids are matched in parallel against a
// flip-flop directory; counts and queue pointers live in a synchronous
// record memory and queued task ids in a waiter memory of one window per slot.
module semaphore_table_with_wait_queues (
  input  logic        clk_i,
  input  logic        rst_ni,
  semq_req_if.sink    req_i,
  semq_rsp_if.source  rsp_o
);
  import semq_pkg::*;

  state_e state_q, state_d;

  // Captured request item.
  action_e                 act_q;
  logic [IdW-1:0]          id_q;
  logic signed [InitW-1:0] init_q;
  logic [TaskBits-1:0]     task_q;
  logic [SlotW-1:0]        slot_q, slot_d;

  logic [NextIdW-1:0] next_id_q, next_id_d;
  res_t               pend_q, pend_d;
  res_t               out_q;
  logic               out_valid_q, out_valid_d;

  // Memories and their ports.
  rec_t                rec_mem [NumSem];
  logic [TaskBits-1:0] wait_mem [NumSem * QueueDepth];
  rec_t                rec_rd_q;
  logic [TaskBits-1:0] wait_rd_q;

  logic                rec_we, rec_re;
  logic [SlotW-1:0]    rec_waddr, rec_raddr;
  rec_t                rec_wdata;
  logic                wait_we, wait_re;
  logic [WAddrW-1:0]   wait_waddr, wait_raddr;

  dir_wr_t  dir_wr;
  dir_rsp_t dir_rsp;

  logic                     req_fire, out_free;
  logic                     create_ok;
  logic                     cnt_nonpos, up_nonpos, need_wake;
  logic signed [CountW-1:0] up_count;

  semq_dir u_dir (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lookup_id_i (id_q),
    .wr_i        (dir_wr),
    .rsp_o       (dir_rsp)
  );

  // Shared decisions.
  assign req_fire   = req_i.valid && req_i.ready;
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign create_ok  = !init_q[InitW-1] && dir_rsp.has_free && !next_id_q[NextIdW-1];
  assign cnt_nonpos = rec_rd_q.count[CountW-1] || (rec_rd_q.count == '0);
  assign up_count   = (rec_rd_q.count < CountMax) ? rec_rd_q.count + CountW'(1)
                                                  : rec_rd_q.count;
  assign up_nonpos  = up_count[CountW-1] || (up_count == '0);
  assign need_wake  = (act_q == ACT_UP) && up_nonpos && (rec_rd_q.len != '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (act_q != ACT_CREATE && dir_rsp.hit) begin
          state_d = S_MODIFY;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_MODIFY: begin
        state_d = need_wake ? S_WAKE : S_FINISH;
      end
      S_WAKE: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory accesses, directory updates and result assembly per state.
  always_comb begin
    rec_we      = 1'b0;
    rec_re      = 1'b0;
    rec_waddr   = slot_q;
    rec_raddr   = dir_rsp.hit_slot;
    rec_wdata   = rec_rd_q;
    wait_we     = 1'b0;
    wait_re     = 1'b0;
    wait_waddr  = waddr(slot_q, qpos(rec_rd_q.head, rec_rd_q.len));
    wait_raddr  = waddr(slot_q, rec_rd_q.head);
    dir_wr      = '0;
    slot_d      = slot_q;
    next_id_d   = next_id_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: ;
      S_LOOKUP: begin
        pend_d = '0;
        if (act_q == ACT_CREATE) begin
          if (init_q[InitW-1]) begin
            pend_d.status = ST_INVALID;
          end else if (!create_ok) begin
            pend_d.status = ST_NOSPACE;
          end else begin
            dir_wr.alloc       = 1'b1;
            dir_wr.alloc_slot  = dir_rsp.free_slot;
            dir_wr.alloc_ident = next_id_q[IdW-1:0];
            rec_we             = 1'b1;
            rec_waddr          = dir_rsp.free_slot;
            rec_wdata.count    = CountW'(init_q);
            rec_wdata.head     = '0;
            rec_wdata.len      = '0;
            pend_d.created_id  = next_id_q[IdW-1:0];
            next_id_d          = next_id_q + NextIdW'(1);
          end
        end else if (!dir_rsp.hit) begin
          pend_d.status = ST_INVALID;
        end else begin
          rec_re = 1'b1;
          slot_d = dir_rsp.hit_slot;
        end
      end
      S_MODIFY: begin
        case (act_q)
          ACT_DOWN: begin
            if (cnt_nonpos) begin
              if (rec_rd_q.len >= QLenW'(QueueDepth)) begin
                pend_d.status = ST_NOSPACE;
              end else begin
                wait_we         = 1'b1;
                rec_we          = 1'b1;
                rec_wdata.count = rec_rd_q.count - CountW'(1);
                rec_wdata.len   = rec_rd_q.len + QLenW'(1);
                pend_d.sleeps   = 1'b1;
              end
            end else begin
              rec_we          = 1'b1;
              rec_wdata.count = rec_rd_q.count - CountW'(1);
            end
          end
          ACT_UP: begin
            if (need_wake) begin
              wait_re = 1'b1;
            end else begin
              rec_we          = 1'b1;
              rec_wdata.count = up_count;
            end
          end
          ACT_CLOSE: begin
            if (rec_rd_q.len != '0) begin
              pend_d.status = ST_INVALID;
            end else begin
              dir_wr.free_en   = 1'b1;
              dir_wr.free_slot = slot_q;
            end
          end
          default: ;
        endcase
      end
      S_WAKE: begin
        rec_we            = 1'b1;
        rec_wdata.count   = up_count;
        rec_wdata.head    = qpos(rec_rd_q.head, QLenW'(1));
        rec_wdata.len     = rec_rd_q.len - QLenW'(1);
        pend_d.wake_valid = 1'b1;
        pend_d.wake_task  = CallerW'(wait_rd_q);
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_id_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_id_q   <= next_id_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      act_q  <= req_i.action;
      id_q   <= req_i.target_id;
      init_q <= req_i.initial_count;
      task_q <= TaskBits'(req_i.caller_task);
    end
    slot_q <= slot_d;
    pend_q <= pend_d;
    if (state_q == S_FINISH && out_free) begin
      out_q <= pend_q;
    end
  end

  // Record memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (rec_re) begin
      rec_rd_q <= rec_mem[rec_raddr];
    end
  end

  // Waiter memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wait_we) begin
      wait_mem[wait_waddr] <= task_q;
    end
    if (wait_re) begin
      wait_rd_q <= wait_mem[wait_raddr];
    end
  end

  // Channel outputs.
  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_q.status;
  assign rsp_o.created_id    = out_q.created_id;
  assign rsp_o.caller_sleeps = out_q.sleeps;
  assign rsp_o.wake_valid    = out_q.wake_valid;
  assign rsp_o.wake_task     = out_q.wake_task;

endmodule

### bench/tb.sv
// Self-checking testbench for the semaphore table with FIFO wait queues.
`timescale 1ns / 1ps

module tb;
  import semq_pkg::*;

  // One request item as the bench sees it.
  typedef struct packed {
    action_e                 action;
    logic [IdW-1:0]          target_id;
    logic signed [InitW-1:0] initial_count;
    logic [CallerW-1:0]      caller_task;
  } sem_req_t;

  // Mirror of the semaphore table plus the queue of results still owed.
  class sem_table_model;
    bit                     slot_used[NumSem];
    bit [IdW-1:0]           slot_id[NumSem];
    bit signed [CountW-1:0] slot_cnt[NumSem];
    bit [CallerW-1:0]       waiters[NumSem][QueueDepth];
    bit [QPosW-1:0]         q_head[NumSem];
    bit [QLenW-1:0]         q_len[NumSem];
    bit [NextIdW-1:0]       next_id;
    res_t                   expected_results[$];
    int                     mismatches;

    // Apply an accepted request to the mirror and queue the answer it owes.
    function void note_request(sem_req_t r);
      res_t             res;
      int               s;
      int               pos;
      bit [CallerW-1:0] caller;
      res = '0;
      res.status = ST_OK;
      caller = r.caller_task & CallerW'((1 << TaskBits) - 1);
      s = -1;
      if (r.action == ACT_CREATE) begin
        if (r.initial_count < 0) begin
          res.status = ST_INVALID;
        end else begin
          for (int i = 0; i < NumSem; i++) begin
            if (!slot_used[i] && s < 0) s = i;
          end
          if (s < 0 || next_id >= NextIdW'(1 << IdW)) begin
            res.status = ST_NOSPACE;
          end else begin
            slot_used[s] = 1'b1;
            slot_id[s] = IdW'(next_id);
            slot_cnt[s] = r.initial_count;
            q_head[s] = '0;
            q_len[s] = '0;
            res.created_id = IdW'(next_id);
            next_id = next_id + 1'b1;
          end
        end
      end else begin
        for (int i = 0; i < NumSem; i++) begin
          if (slot_used[i] && slot_id[i] == r.target_id && s < 0) s = i;
        end
        if (s < 0) begin
          res.status = ST_INVALID;
        end else begin
          case (r.action)
            ACT_DOWN: begin
              if (slot_cnt[s] <= 0) begin
                // The caller has to wait; a full queue refuses it and keeps the count.
                if (q_len[s] >= QueueDepth) begin
                  res.status = ST_NOSPACE;
                end else begin
                  pos = (int'(q_head[s]) + int'(q_len[s])) % QueueDepth;
                  waiters[s][pos] = caller;
                  q_len[s] = q_len[s] + 1'b1;
                  slot_cnt[s] = slot_cnt[s] - 1;
                  res.sleeps = 1'b1;
                end
              end else begin
                slot_cnt[s] = slot_cnt[s] - 1;
              end
            end
            ACT_UP: begin
              // The count saturates at its maximum; while it is still at or below zero, the oldest waiter is released.
              if (slot_cnt[s] < CountMax) slot_cnt[s] = slot_cnt[s] + 1;
              if (slot_cnt[s] <= 0 && q_len[s] != 0) begin
                res.wake_valid = 1'b1;
                res.wake_task = waiters[s][q_head[s]];
                q_head[s] = QPosW'((int'(q_head[s]) + 1) % QueueDepth);
                q_len[s] = q_len[s] - 1'b1;
              end
            end
            ACT_CLOSE: begin
              if (q_len[s] != 0) res.status = ST_INVALID;
              else slot_used[s] = 1'b0;
            end
            default: ;
          endcase
        end
      end
      expected_results.push_back(res);
    endfunction

    // Compare one result item with the oldest answer owed.
    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $error("result item with no request pending: status %0d", got.status);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.created_id !== want.created_id) begin
        $error("created_id: expected %0d, got %0d", want.created_id, got.created_id);
        mismatches++;
      end
      if (got.sleeps !== want.sleeps) begin
        $error("caller_sleeps: expected %0d, got %0d", want.sleeps, got.sleeps);
        mismatches++;
      end
      if (got.wake_valid !== want.wake_valid) begin
        $error("wake_valid: expected %0d, got %0d", want.wake_valid, got.wake_valid);
        mismatches++;
      end
      if (got.wake_task !== want.wake_task) begin
        $error("wake_task: expected %0d, got %0d", want.wake_task, got.wake_task);
        mismatches++;
      end
    endfunction

    // Pick a live semaphore at random, optionally one with nobody waiting.
    function bit pick_id(bit want_empty, output bit [IdW-1:0] id);
      int cand[$];
      for (int i = 0; i < NumSem; i++) begin
        if (slot_used[i] && (!want_empty || q_len[i] == 0)) cand.push_back(i);
      end
      id = '0;
      if (cand.size() == 0) return 1'b0;
      id = slot_id[cand[$urandom_range(cand.size() - 1)]];
      return 1'b1;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  semq_req_if req_if ();
  semq_rsp_if rsp_if ();

  sem_table_model model = new;
  int src_idle_pct;
  int snk_idle_pct;
  int requests_sent;

  semaphore_table_with_wait_queues i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // 8 ns clock.
  always #4 clk_i = ~clk_i;

  // Issue one request item, with random idle cycles ahead of it.
  task automatic send(action_e act, bit [IdW-1:0] id, logic signed [InitW-1:0] init,
                      bit [CallerW-1:0] caller);
    sem_req_t r;
    r.action = act;
    r.target_id = id;
    r.initial_count = init;
    r.caller_task = caller;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.target_id <= id;
    req_if.initial_count <= init;
    req_if.caller_task <= caller;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    model.note_request(r);
    requests_sent++;
  endtask

  // Hold off new requests until every owed result has been taken.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (model.expected_results.size() != 0);
  endtask

  // Mostly a live id; otherwise a stale or never issued one.
  function automatic bit [IdW-1:0] target_id_for(bit want_empty);
    bit [IdW-1:0] id;
    int           r;
    r = $urandom_range(99);
    if (r < 85 && model.pick_id(want_empty, id)) return id;
    if (r < 95) return IdW'($urandom_range(0, int'(model.next_id)));
    return IdW'($urandom);
  endfunction

  // Random traffic built from bursts on live semaphores, with some noise.
  task automatic run_random(int n_items);
    int                      stop_at;
    int                      pick;
    bit [IdW-1:0]            id;
    logic signed [InitW-1:0] start;
    stop_at = requests_sent + n_items;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick == 0) begin
        drain_results();
      end else if (pick < 28) begin
        // A run of downs, long enough at times to overflow the wait queue.
        id = target_id_for(1'b0);
        repeat ($urandom_range(1, 11)) send(ACT_DOWN, id, InitW'($urandom), CallerW'($urandom));
      end else if (pick < 55) begin
        id = target_id_for(1'b0);
        repeat ($urandom_range(1, 11)) send(ACT_UP, id, InitW'($urandom), CallerW'($urandom));
      end else if (pick < 72) begin
        // Creates with small, maximal, negative and arbitrary starting counts.
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(9))
            0: start = {1'b1, 16'($urandom)};
            1: start = InitW'(65535);
            2: start = InitW'($urandom);
            3: start = InitW'($urandom_range(0, 65535));
            default: start = InitW'($urandom_range(0, 3));
          endcase
          send(ACT_CREATE, IdW'($urandom), start, CallerW'($urandom));
        end
      end else if (pick < 88) begin
        send(ACT_CLOSE, target_id_for(1'b1), InitW'($urandom), CallerW'($urandom));
      end else begin
        send(action_e'($urandom_range(0, 3)), IdW'($urandom), InitW'($urandom),
             CallerW'($urandom));
      end
    end
  endtask

  // Response side: check each taken result and stall at random.
  initial begin
    res_t got;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        got.status = rsp_if.status;
        got.created_id = rsp_if.created_id;
        got.sleeps = rsp_if.caller_sleeps;
        got.wake_valid = rsp_if.wake_valid;
        got.wake_task = rsp_if.wake_task;
        model.check_result(got);
      end
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Main sequence: reset, directed cases, then three random phases.
  initial begin
    src_idle_pct = 28;
    snk_idle_pct = 65;
    requests_sent = 0;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.action <= ACT_CREATE;
    req_if.target_id <= '0;
    req_if.initial_count <= '0;
    req_if.caller_task <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: count limits, waking order, refused closes and unknown ids.
    send(ACT_CREATE, 16'hFFFF, InitW'(0), 8'h00);
    send(ACT_CREATE, 16'h0000, InitW'(65535), 8'hFF);
    send(ACT_CREATE, 16'h0001, InitW'(-1), 8'h00);
    send(ACT_CREATE, 16'h0001, InitW'(-65536), 8'h00);
    send(ACT_UP, 16'd1, InitW'(0), 8'h11);
    send(ACT_DOWN, 16'd1, InitW'(0), 8'h22);
    send(ACT_DOWN, 16'd0, InitW'(0), 8'hFF);
    send(ACT_DOWN, 16'd0, InitW'(0), 8'h00);
    send(ACT_DOWN, 16'd0, InitW'(0), 8'hA5);
    send(ACT_CLOSE, 16'd0, InitW'(0), 8'h00);
    send(ACT_UP, 16'd0, InitW'(0), 8'h01);
    send(ACT_UP, 16'd0, InitW'(0), 8'h02);
    send(ACT_UP, 16'd0, InitW'(0), 8'h03);
    send(ACT_UP, 16'd0, InitW'(0), 8'h04);
    send(ACT_DOWN, 16'd0, InitW'(0), 8'h5A);
    send(ACT_DOWN, 16'hFFFF, InitW'(0), 8'h00);
    send(ACT_UP, 16'hFFFF, InitW'(0), 8'h00);
    send(ACT_CLOSE, 16'hFFFF, InitW'(0), 8'h00);
    send(ACT_CLOSE, 16'd0, InitW'(0), 8'h00);
    send(ACT_DOWN, 16'd0, InitW'(0), 8'h00);
    send(ACT_CLOSE, 16'd1, InitW'(0), 8'h00);

    run_random(600);
    drain_results();
    src_idle_pct = 65;
    snk_idle_pct = 28;
    run_random(600);
    drain_results();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(600);

    req_if.valid <= 1'b0;
    while (model.expected_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (model.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
